>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

>>> rtl/core/xed_pkg.sv
// Package: constants, types and helper functions of the XML entity decoder.
`timescale 1ns / 1ps
`default_nettype none
package xed_pkg;

   localparam int MAX_ENTITY_DEF = 16;
   localparam logic [15:0] OUT_LIMIT_RST = 16'hFFFF;
   localparam logic [4:0] RESULT_CAP = 5'd19;
   localparam int NUM_NAMES = 5;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LX   = 8'h78;
   localparam logic [7:0] CH_UX   = 8'h58;

   localparam logic [20:0] CP_MAX = 21'h10FFFF;
   localparam logic [20:0] CP_SAT = 21'h110000;

   // Decoded entity: code point and UTF-8 length.
   typedef struct packed {
      logic        hit;
      logic [20:0] cp;
      logic [2:0]  nbytes;
   } xed_match_type;

   // Length of named entity i.
   function automatic logic [2:0] name_len(input int i);
      case (i)
         0: name_len = 3'd3;
         1: name_len = 3'd2;
         2: name_len = 3'd2;
         3: name_len = 3'd4;
         default: name_len = 3'd4;
      endcase
   endfunction

   // Character j of named entity i.
   function automatic logic [7:0] name_char(input int i, input logic [1:0] j);
      logic [31:0] s;
      case (i)
         0: s = "amp ";
         1: s = "lt  ";
         2: s = "gt  ";
         3: s = "quot";
         default: s = "apos";
      endcase
      case (j)
         2'd0: name_char = s[31:24];
         2'd1: name_char = s[23:16];
         2'd2: name_char = s[15:8];
         default: name_char = s[7:0];
      endcase
   endfunction

   // Character that named entity i stands for.
   function automatic logic [7:0] name_out(input int i);
      case (i)
         0: name_out = 8'h26;
         1: name_out = 8'h3C;
         2: name_out = 8'h3E;
         3: name_out = 8'h22;
         default: name_out = 8'h27;
      endcase
   endfunction

   // Hex digit value; bit 4 set when the byte is no hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         hex_val = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         hex_val = {1'b0, 4'(c - 8'h37)};
      end else begin
         hex_val = 5'b10000;
      end
   endfunction

   // Byte idx of the UTF-8 encoding of cp, nb bytes long.
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] nb,
                                            input logic [1:0] idx);
      logic [7:0] r;
      r = {1'b0, cp[6:0]};
      case (nb)
         3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         3'd3: begin
            case (idx)
               2'd0: r = {4'b1110, cp[15:12]};
               2'd1: r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0: r = {5'b11110, cp[20:18]};
               2'd1: r = {2'b10, cp[17:12]};
               2'd2: r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         default: r = cp[7:0];
      endcase
      utf8_byte = r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/xed_req_if.sv
// Interface: raw text byte channel into the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface xed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/xed_rsp_if.sv
// Interface: decoded byte channel out of the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface xed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       stream_done;
   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output stream_done, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input run_last,
                 input stream_done, output ready);
endinterface
`default_nettype wire

>>> rtl/core/xed_entity_match.sv
// Incremental matcher: tracks named and numeric entity parse as bytes are appended.
`timescale 1ns / 1ps
`default_nettype none
module xed_entity_match #(
   parameter int MAX_ENTITY = xed_pkg::MAX_ENTITY_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            start,
   input  wire logic                            append,
   input  wire logic [7:0]                      ch,
   input  wire logic [$clog2(MAX_ENTITY+1)-1:0] txt_len,
   output xed_pkg::xed_match_type               match
);
   localparam int FW = $clog2(MAX_ENTITY + 1);

   logic [xed_pkg::NUM_NAMES-1:0] name_ok_ff, name_ok_in;
   logic        num_ok_ff, num_ok_in;
   logic        hex_ff, hex_in;
   logic [20:0] cp_ff, cp_in;
   logic [4:0]  hv;
   logic [24:0] acc;
   logic        dig_ok;

   // Next parse state for the byte at text position txt_len
   always_comb begin
      hv = xed_pkg::hex_val(ch);
      name_ok_in = name_ok_ff;
      num_ok_in = num_ok_ff;
      hex_in = hex_ff;
      cp_in = cp_ff;
      for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
         name_ok_in[i] = name_ok_ff[i] && (txt_len < FW'(xed_pkg::name_len(i)))
                         && (ch == xed_pkg::name_char(i, txt_len[1:0]));
      end
      dig_ok = !hv[4] && (hex_ff || (hv[3:0] < 4'd10));
      acc = hex_ff ? ({cp_ff, 4'b0000} | 25'(hv[3:0]))
                   : (25'({cp_ff, 3'b000}) + 25'({cp_ff, 1'b0}) + 25'(hv[3:0]));
      if (txt_len == FW'(0)) begin
         num_ok_in = (ch == xed_pkg::CH_HASH);
         hex_in = 1'b0;
         cp_in = '0;
      end else if (txt_len == FW'(1)) begin
         if (ch == xed_pkg::CH_LX || ch == xed_pkg::CH_UX) begin
            hex_in = 1'b1;
         end else if (hv[4] || hv[3:0] >= 4'd10) begin
            num_ok_in = 1'b0;
         end else begin
            cp_in = 21'(hv[3:0]);
         end
      end else if (!dig_ok) begin
         num_ok_in = 1'b0;
      end else begin
         cp_in = (acc > 25'(xed_pkg::CP_MAX)) ? xed_pkg::CP_SAT : acc[20:0];
      end
   end

   // Parse state registers, restarted at each '&'
   always_ff @(posedge clock) begin
      if (start) begin
         name_ok_ff <= '1;
         num_ok_ff <= 1'b0;
         hex_ff <= 1'b0;
         cp_ff <= '0;
      end else if (append) begin
         name_ok_ff <= name_ok_in;
         num_ok_ff <= num_ok_in;
         hex_ff <= hex_in;
         cp_ff <= cp_in;
      end
   end

   // Verdict for an entity closed now by ';'
   always_comb begin
      match.hit = num_ok_ff && (cp_ff != '0) && (cp_ff <= xed_pkg::CP_MAX);
      match.cp = cp_ff;
      if (cp_ff <= 21'd127) begin
         match.nbytes = 3'd1;
      end else if (cp_ff <= 21'h7FF) begin
         match.nbytes = 3'd2;
      end else if (cp_ff <= 21'hFFFF) begin
         match.nbytes = 3'd3;
      end else begin
         match.nbytes = 3'd4;
      end
      for (int i = xed_pkg::NUM_NAMES - 1; i >= 0; i--) begin
         if (name_ok_ff[i] && txt_len == FW'(xed_pkg::name_len(i))) begin
            match.hit = 1'b1;
            match.cp = 21'(xed_pkg::name_out(i));
            match.nbytes = 3'd1;
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/xml_entity_decoder_core.sv
// Top level: streaming XML entity decoder with a byte sequencer and replay queue.
//
//  channel   dir  payload                                       transfer when
//  req_chan  in   in_byte, in_last                              valid & ready
//  rsp_chan  out  out_byte, byte_valid, run_last, stream_done   valid & ready
//  csr       in   csr_wdata = out_limit                         csr_we
//
// One byte at a time; req_chan.ready is high only between items.
// A plain byte passes accept, process, queue check and hand-off in turn.
// Each extra result adds an emit step; a replay copies each held byte into the
// rescan queue and takes each rescanned byte through queue check, queue read
// and process.
// Sync reset clears sequencer and counts, loads out_limit 16'hFFFF; no clearing pass.
// rsp_chan stalls hold the sequencer once both the output and pending registers are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module xml_entity_decoder_core #(
   parameter int MAX_ENTITY = xed_pkg::MAX_ENTITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   xed_req_if.sink          req_chan,
   xed_rsp_if.source        rsp_chan
);
   localparam int FW = $clog2(MAX_ENTITY + 1);
   localparam int AW = $clog2(MAX_ENTITY);
   localparam int QW = $clog2(MAX_ENTITY + 2);
   localparam int QD = 1 << QW;
   localparam logic [QW:0] QD_L = (QW + 1)'(QD);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PROC  = 9'b000000010,
      ST_NEXT  = 9'b000000100,
      ST_QRD   = 9'b000001000,
      ST_COPY  = 9'b000010000,
      ST_EMIT  = 9'b000100000,
      ST_FLUSH = 9'b001000000,
      ST_ENDM  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] out_limit_ff;
   logic [15:0] emitted_ff, emitted_in;
   logic [4:0]  res_n_ff, res_n_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [QW-1:0] head_ff, head_in;
   logic [QW:0]   qlen_ff, qlen_in;
   logic [7:0]  cur_ff;
   logic        last_ff, first_ff, first_in;
   logic [20:0] dec_cp_ff, dec_cp_in;
   logic [2:0]  dec_nb_ff, dec_nb_in;
   logic [1:0]  eidx_ff, eidx_in;

   // Memories: entity buffer and rescan queue
   logic [7:0]  ebuf [MAX_ENTITY];
   logic [7:0]  qmem [QD];
   logic [7:0]  eb_rd_ff, q_rd_ff;
   logic        eb_we, q_we;
   logic [AW-1:0] eb_waddr, rd_addr;
   logic [7:0]  eb_wdata, q_wdata;

   // Pending result and output register
   logic        pend_v_ff;
   logic [7:0]  pend_byte_ff;
   logic        pend_bv_ff, pend_sd_ff;
   logic        out_v_ff;
   logic [7:0]  out_byte_ff;
   logic        out_bv_ff, out_rl_ff, out_sd_ff;

   logic        push_en, push_bv, push_sd, release_en;
   logic [7:0]  push_byte;
   logic        put_req, put_ok, can_push, advance, out_free;
   logic [7:0]  put_byte;
   logic [7:0]  b;
   logic [FW-1:0] fill_m1;
   logic [4:0]  cap;
   logic        m_start, m_append;
   xed_pkg::xed_match_type match;

   xed_entity_match #(.MAX_ENTITY(MAX_ENTITY)) u_match (
      .clock   (clock),
      .start   (m_start),
      .append  (m_append),
      .ch      (b),
      .txt_len (fill_m1),
      .match   (match)
   );

   assign b = first_ff ? cur_ff : q_rd_ff;
   assign fill_m1 = fill_ff - FW'(1);
   assign cap = last_ff ? (xed_pkg::RESULT_CAP - 5'd1) : xed_pkg::RESULT_CAP;
   assign out_free = !out_v_ff || rsp_chan.ready;
   assign can_push = !pend_v_ff || out_free;
   assign put_ok = (emitted_ff < out_limit_ff) && (res_n_ff < cap);
   assign advance = !put_req || !put_ok || can_push;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      emitted_in = emitted_ff;
      res_n_in = res_n_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      head_in = head_ff;
      qlen_in = qlen_ff;
      first_in = first_ff;
      dec_cp_in = dec_cp_ff;
      dec_nb_in = dec_nb_ff;
      eidx_in = eidx_ff;
      eb_we = 1'b0;
      eb_waddr = fill_ff[AW-1:0];
      eb_wdata = b;
      q_we = 1'b0;
      q_wdata = b;
      rd_addr = idx_ff;
      put_req = 1'b0;
      put_byte = b;
      push_en = 1'b0;
      push_byte = put_byte;
      push_bv = 1'b1;
      push_sd = 1'b0;
      release_en = 1'b0;
      m_start = 1'b0;
      m_append = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               first_in = 1'b1;
               res_n_in = '0;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            if (fill_ff == FW'(0)) begin
               if (b == xed_pkg::CH_AMP) begin
                  eb_we = 1'b1;
                  eb_waddr = '0;
                  m_start = 1'b1;
                  fill_in = FW'(1);
                  state_in = ST_NEXT;
               end else begin
                  put_req = 1'b1;
                  if (advance) state_in = ST_NEXT;
               end
            end else if (b == xed_pkg::CH_SEMI && match.hit) begin
               dec_cp_in = match.cp;
               dec_nb_in = match.nbytes;
               eidx_in = '0;
               state_in = ST_EMIT;
            end else if (b == xed_pkg::CH_SEMI || fill_ff == FW'(MAX_ENTITY)) begin
               // unmatched: literal '&', requeue held bytes then this byte
               put_req = 1'b1;
               put_byte = xed_pkg::CH_AMP;
               if (advance) begin
                  q_we = 1'b1;
                  head_in = head_ff - QW'(1);
                  qlen_in = qlen_ff + (QW + 1)'(1);
                  if (fill_ff > FW'(1)) begin
                     rd_addr = fill_m1[AW-1:0];
                     idx_in = fill_m1[AW-1:0];
                     state_in = ST_COPY;
                  end else begin
                     fill_in = '0;
                     state_in = ST_NEXT;
                  end
               end
            end else begin
               eb_we = 1'b1;
               m_append = 1'b1;
               fill_in = fill_ff + FW'(1);
               state_in = ST_NEXT;
            end
         end
         ST_COPY: begin
            q_we = 1'b1;
            q_wdata = eb_rd_ff;
            head_in = head_ff - QW'(1);
            qlen_in = qlen_ff + (QW + 1)'(1);
            if (idx_ff > AW'(1)) begin
               rd_addr = idx_ff - AW'(1);
               idx_in = idx_ff - AW'(1);
            end else begin
               fill_in = '0;
               state_in = ST_NEXT;
            end
         end
         ST_EMIT: begin
            put_req = 1'b1;
            put_byte = xed_pkg::utf8_byte(dec_cp_ff, dec_nb_ff, eidx_ff);
            if (advance) begin
               if (3'(eidx_ff) == dec_nb_ff - 3'd1) begin
                  fill_in = '0;
                  state_in = ST_NEXT;
               end else begin
                  eidx_in = eidx_ff + 2'd1;
               end
            end
         end
         ST_NEXT: begin
            if (qlen_ff != '0) begin
               state_in = ST_QRD;
            end else if (last_ff) begin
               if (fill_ff != FW'(0)) begin
                  rd_addr = '0;
                  idx_in = '0;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_ENDM;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QRD: begin
            head_in = head_ff + QW'(1);
            qlen_in = qlen_ff - (QW + 1)'(1);
            first_in = 1'b0;
            state_in = ST_PROC;
         end
         ST_FLUSH: begin
            put_req = 1'b1;
            put_byte = eb_rd_ff;
            if (advance) begin
               if (idx_ff == fill_m1[AW-1:0]) begin
                  state_in = ST_ENDM;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  rd_addr = idx_ff + AW'(1);
               end
            end
         end
         ST_ENDM: begin
            if (can_push) begin
               push_en = 1'b1;
               push_byte = '0;
               push_bv = 1'b0;
               push_sd = 1'b1;
               emitted_in = '0;
               fill_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               release_en = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // data byte passes the limit and cap checks
      if (put_req && put_ok && can_push) begin
         push_en = 1'b1;
         push_byte = put_byte;
         emitted_in = emitted_ff + 16'd1;
         res_n_in = res_n_ff + 5'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_limit_ff <= xed_pkg::OUT_LIMIT_RST;
         emitted_ff <= '0;
         res_n_ff <= '0;
         fill_ff <= '0;
         head_ff <= '0;
         qlen_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) out_limit_ff <= csr_wdata;
         emitted_ff <= emitted_in;
         res_n_ff <= res_n_in;
         fill_ff <= fill_in;
         head_ff <= head_in;
         qlen_ff <= qlen_in;
         if (push_en) begin
            pend_v_ff <= 1'b1;
         end else if (release_en) begin
            pend_v_ff <= 1'b0;
         end
         if ((push_en && pend_v_ff) || release_en) begin
            out_v_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_chan.valid) begin
         cur_ff <= req_chan.in_byte;
         last_ff <= req_chan.in_last;
      end
      first_ff <= first_in;
      idx_ff <= idx_in;
      dec_cp_ff <= dec_cp_in;
      dec_nb_ff <= dec_nb_in;
      eidx_ff <= eidx_in;
      if ((push_en && pend_v_ff) || release_en) begin
         out_byte_ff <= pend_byte_ff;
         out_bv_ff <= pend_bv_ff;
         out_sd_ff <= pend_sd_ff;
         out_rl_ff <= release_en;
      end
      if (push_en) begin
         pend_byte_ff <= push_byte;
         pend_bv_ff <= push_bv;
         pend_sd_ff <= push_sd;
      end
   end

   // Entity buffer memory
   always_ff @(posedge clock) begin
      if (eb_we) ebuf[eb_waddr] <= eb_wdata;
      eb_rd_ff <= ebuf[rd_addr];
   end

   // Rescan queue memory: prepend at head-1, pop at head; popped byte held while processed
   always_ff @(posedge clock) begin
      if (q_we) qmem[head_ff - QW'(1)] <= q_wdata;
      if (state_ff == ST_QRD) q_rd_ff <= qmem[head_ff];
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.byte_valid = out_bv_ff;
   assign rsp_chan.run_last = out_rl_ff;
   assign rsp_chan.stream_done = out_sd_ff;

   `ASSERT_CLK(a_idle_no_pend, clock, reset, (state_ff == ST_IDLE) |-> !pend_v_ff)
   `ASSERT_CLK(a_qlen_bound, clock, reset, qlen_ff <= QD_L)
   `ASSERT_CLK(a_fill_bound, clock, reset, fill_ff <= FW'(MAX_ENTITY))
   `ASSERT_NEVER(a_marker_shape, clock, reset, out_v_ff && out_sd_ff && (out_bv_ff || !out_rl_ff))
endmodule
`default_nettype wire
